// ===== rtl/core/tdbs_pkg.sv =====
// Types, constants and Q.28 fixed-point helpers shared by the box spline unit
package tdbs_pkg;

    localparam int QW = 32;
    localparam int QF = 28;

    typedef logic signed [QW-1:0] t_q;

    localparam t_q Q_ONE         = 32'sd268435456;
    localparam t_q Q_HALF        = 32'sd134217728;
    localparam t_q Q_TWO         = 32'sd536870912;
    localparam t_q Q_THREE       = 32'sd805306368;
    localparam t_q Q_INV_SQRT3   = 32'sd154981283;
    localparam t_q Q_FIVE_THIRDS = 32'sd447392427;
    localparam t_q Q_FIVE_SIXTHS = 32'sd223696213;
    localparam t_q Q_THIRD       = 32'sd89478485;
    localparam t_q Q_SIXTH       = 32'sd44739243;

    typedef enum logic [1:0] {
        REG_INNER  = 2'd0,
        REG_MIDDLE = 2'd1,
        REG_OUTER  = 2'd2,
        REG_ZERO   = 2'd3
    } t_region;

    typedef struct packed {
        t_q      u;
        t_q      v;
        t_region region;
    } t_fold_data;

    typedef struct packed {
        t_q      tg;
        t_q      lane;
        t_region region;
    } t_poly_data;

    // Q.28 product, sign-magnitude, rounded to nearest with ties away from zero
    function automatic t_q qmul(input t_q a, input t_q b);
        logic [QW-1:0]   ma;
        logic [QW-1:0]   mb;
        logic [2*QW-1:0] p;
        logic [QW-1:0]   pm;
        ma = $unsigned(a);
        if (a[QW-1]) ma = ~ma + QW'(1);
        mb = $unsigned(b);
        if (b[QW-1]) mb = ~mb + QW'(1);
        p  = ma * mb;
        p  = p + ((2*QW)'(1) << (QF - 1));
        pm = p[QF +: QW];
        return (a[QW-1] ^ b[QW-1]) ? -$signed(pm) : $signed(pm);
    endfunction

    // Rounded right shift, same as a product with 2^-s
    function automatic t_q qshr(input t_q a, input int unsigned s);
        logic [QW-1:0] m;
        m = $unsigned(a);
        if (a[QW-1]) m = ~m + QW'(1);
        m = (m + ((QW'(1) << s) >> 1)) >> s;
        return a[QW-1] ? -$signed(m) : $signed(m);
    endfunction

endpackage

// ===== rtl/core/tdbs_fold.sv =====
// Front pipeline: coordinate magnitudes, sqrt3 scaling, symmetry fold, region pick
module tdbs_fold
    import tdbs_pkg::*;
#(
    parameter int COORD_WIDTH     = 16,
    parameter int COORD_FRAC_BITS = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [COORD_WIDTH-1:0] i_coord_x,
    input  logic signed [COORD_WIDTH-1:0] i_coord_y,
    output logic                          o_valid,
    input  logic                          i_stall,
    output t_fold_data                    o_data
);

    localparam int NS   = 4;
    localparam int MW   = (COORD_WIDTH > COORD_FRAC_BITS + 3) ? COORD_WIDTH
                                                              : COORD_FRAC_BITS + 3;
    localparam logic [MW-1:0] MAG_LIM = MW'(4) << COORD_FRAC_BITS;
    localparam int UPSH = QF - COORD_FRAC_BITS;

    // |c| clamped to 4.0, in Q.28; the most negative code comes out exact
    function automatic t_q coord_mag(input logic signed [COORD_WIDTH-1:0] c);
        logic [COORD_WIDTH-1:0] m;
        logic [MW-1:0]          mw;
        m = $unsigned(c);
        if (c[COORD_WIDTH-1]) m = ~m + COORD_WIDTH'(1);
        mw = MW'(m);
        if (mw > MAG_LIM) mw = MAG_LIM;
        return $signed(QW'(mw) << UPSH);
    endfunction

    logic [NS-1:0] r_v;
    logic [NS-1:0] en;

    t_q      r0_ax, r0_ayr;
    t_q      r1_ax, r1_ay;
    t_q      r2_u, r2_v;
    t_q      r3_u, r3_v;
    t_region r3_region;

    t_q                n2_d, n2_s;
    logic signed [QW:0] n3_u2;
    t_q                n3_u;
    t_region           n3_region;

    always_comb begin
        en[NS-1] = !r_v[NS-1] || !i_stall;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_stall = !en[0];
    assign o_valid = r_v[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) r_v[0] <= i_valid;
            for (int k = 1; k < NS; k++) begin
                if (en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    always_comb begin
        n2_d = r1_ax - r1_ay;
        n2_s = r1_ax + r1_ay;
    end

    // fold into the fundamental sector, then classify
    always_comb begin
        n3_u2 = {r2_u, 1'b0};
        n3_u  = (n3_u2 < (QW+1)'(r2_v)) ? r2_v - r2_u : r2_u;
        priority if (r2_v > Q_TWO) begin
            n3_region = REG_ZERO;
        end else if (r2_v < Q_ONE) begin
            n3_region = REG_INNER;
        end else if (n3_u > Q_ONE) begin
            n3_region = REG_OUTER;
        end else begin
            n3_region = REG_MIDDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r0_ax  <= coord_mag(i_coord_x);
            r0_ayr <= coord_mag(i_coord_y);
        end
        if (en[1]) begin
            r1_ax <= r0_ax;
            r1_ay <= qmul(r0_ayr, Q_INV_SQRT3);
        end
        if (en[2]) begin
            // u < 0: u = -u and v = v + |u|, i.e. ax + ay - (ax - ay)
            r2_u <= n2_d[QW-1] ? -n2_d : n2_d;
            r2_v <= n2_d[QW-1] ? n2_s - n2_d : n2_s;
        end
        if (en[3]) begin
            r3_u      <= n3_u;
            r3_v      <= r2_v;
            r3_region <= n3_region;
        end
    end

    assign o_data = '{u: r3_u, v: r3_v, region: r3_region};

endmodule

// ===== rtl/core/tdbs_poly.sv =====
// Polynomial pipeline: shared g*g*tg lane and one region lane, no stage chains more than one product
module tdbs_poly
    import tdbs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  t_fold_data i_data,
    output logic       o_valid,
    input  logic       i_stall,
    output t_poly_data o_data
);

    localparam int NS = 5;

    logic [NS-1:0] r_v;
    logic [NS-1:0] en;

    t_q      r0_g, r0_v, r0_d, r0_ta, r0_la, r0_lb;
    t_region r0_region;
    t_q      r1_gg, r1_a2, r1_m, r1_g, r1_gm1, r1_v, r1_d;
    t_region r1_region;
    t_q      r2_a3, r2_a2, r2_m, r2_g, r2_gm1, r2_v;
    t_region r2_region;
    t_q      r3_tg1, r3_m, r3_g;
    t_region r3_region;
    t_q      r4_tg, r4_lane;
    t_region r4_region;

    t_q n0_g, n0_d, n0_v8, n0_la, n0_lb;
    t_q n2_op, n2_b;
    t_q n3_tg0, n3_op, n3_b;
    t_q n4_lane;

    always_comb begin
        en[NS-1] = !r_v[NS-1] || !i_stall;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_stall = !en[0];
    assign o_valid = r_v[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) r_v[0] <= i_valid;
            for (int k = 1; k < NS; k++) begin
                if (en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    // operand setup: g = u - v/2, d = v - 2
    always_comb begin
        n0_g  = i_data.u - qshr(i_data.v, 1);
        n0_d  = i_data.v - Q_TWO;
        n0_v8 = qshr(i_data.v, 3);
        n0_la = i_data.v;
        n0_lb = i_data.v;
        unique case (i_data.region)
            REG_INNER:  n0_la = Q_FIVE_THIRDS - n0_v8;
            REG_MIDDLE: n0_la = Q_THIRD - n0_v8;
            REG_OUTER: begin
                n0_la = n0_d;
                n0_lb = n0_d;
            end
            REG_ZERO:   n0_la = i_data.v;
        endcase
    end

    always_comb begin
        n2_op = r1_m;
        n2_b  = r1_v;
        unique case (r1_region)
            REG_INNER:  n2_op = r1_m - Q_THREE;
            REG_MIDDLE: n2_op = r1_m + Q_ONE;
            REG_OUTER:  n2_b  = r1_d;
            REG_ZERO:   n2_op = r1_m;
        endcase
    end

    always_comb begin
        n3_tg0 = r2_a2 + r2_a3 - Q_ONE;
        n3_op  = r2_m;
        n3_b   = r2_v;
        unique case (r2_region)
            REG_INNER:  n3_op = r2_m;
            REG_MIDDLE: n3_op = qshr(r2_m, 2) - Q_ONE;
            REG_OUTER:  n3_b  = r2_gm1;
            REG_ZERO:   n3_op = r2_m;
        endcase
    end

    always_comb begin
        unique case (r3_region)
            REG_INNER:  n4_lane = qshr(r3_m, 2);
            REG_MIDDLE: n4_lane = r3_m;
            REG_OUTER:  n4_lane = qmul(r3_m, Q_SIXTH);
            REG_ZERO:   n4_lane = r3_m;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r0_g      <= n0_g;
            r0_v      <= i_data.v;
            r0_d      <= n0_d;
            r0_ta     <= Q_ONE - qshr(i_data.v, 2);
            r0_la     <= n0_la;
            r0_lb     <= n0_lb;
            r0_region <= i_data.region;
        end
        if (en[1]) begin
            r1_gg     <= qmul(r0_g, r0_g);
            r1_a2     <= qmul(r0_ta, r0_v);
            r1_m      <= qmul(r0_la, r0_lb);
            r1_g      <= r0_g;
            r1_gm1    <= r0_g - Q_ONE;
            r1_v      <= r0_v;
            r1_d      <= r0_d;
            r1_region <= r0_region;
        end
        if (en[2]) begin
            r2_a3     <= qmul(r1_gg, Q_SIXTH);
            r2_a2     <= r1_a2;
            r2_m      <= qmul(n2_op, n2_b);
            r2_g      <= r1_g;
            r2_gm1    <= r1_gm1;
            r2_v      <= r1_v;
            r2_region <= r1_region;
        end
        if (en[3]) begin
            r3_tg1    <= qmul(n3_tg0, r2_g);
            r3_m      <= qmul(n3_op, n3_b);
            r3_g      <= r2_g;
            r3_region <= r2_region;
        end
        if (en[4]) begin
            r4_tg     <= qmul(r3_tg1, r3_g);
            r4_lane   <= n4_lane;
            r4_region <= r3_region;
        end
    end

    assign o_data = '{tg: r4_tg, lane: r4_lane, region: r4_region};

endmodule

// ===== rtl/core/tdbs_out.sv =====
// Back pipeline: region sum, rescale to the result format, saturation, output register
module tdbs_out
    import tdbs_pkg::*;
#(
    parameter int RESULT_WIDTH = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  t_poly_data              i_data,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [RESULT_WIDTH-1:0] o_spline_value
);

    localparam int NS   = 2;
    localparam int DNSH = (RESULT_WIDTH < QF) ? QF - RESULT_WIDTH : 0;
    localparam int UPSH = (RESULT_WIDTH > QF) ? RESULT_WIDTH - QF : 0;
    localparam int CVW  = QW + 1 + UPSH;
    localparam logic [CVW-1:0] RND = (CVW'(1) << DNSH) >> 1;

    logic [NS-1:0] r_v;
    logic [NS-1:0] en;

    t_q                      r_sum;
    logic [RESULT_WIDTH-1:0] r_result;

    t_q                      n_sum;
    logic [CVW-1:0]          n_cv;
    logic [RESULT_WIDTH-1:0] n_result;

    always_comb begin
        en[NS-1] = !r_v[NS-1] || !i_stall;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_stall = !en[0];
    assign o_valid = r_v[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) r_v[0] <= i_valid;
            for (int k = 1; k < NS; k++) begin
                if (en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    always_comb begin
        unique case (i_data.region)
            REG_INNER:  n_sum = Q_HALF + i_data.lane + i_data.tg;
            REG_MIDDLE: n_sum = Q_FIVE_SIXTHS + i_data.lane + i_data.tg;
            REG_OUTER:  n_sum = i_data.lane;
            REG_ZERO:   n_sum = '0;
        endcase
    end

    // nonpositive -> 0, otherwise round to nearest and clip at full scale
    always_comb begin
        n_cv = ((CVW'($unsigned(r_sum)) + RND) >> DNSH) << UPSH;
        if (r_sum[QW-1] || (r_sum == '0)) begin
            n_result = '0;
        end else if (|n_cv[CVW-1:RESULT_WIDTH]) begin
            n_result = '1;
        end else begin
            n_result = n_cv[RESULT_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) r_sum <= n_sum;
        if (en[1]) r_result <= n_result;
    end

    assign o_spline_value = r_result;

endmodule

// ===== rtl/core/three_direction_box_spline_eval_unit.sv =====
// Top level of the three-directional box spline evaluator
//
// Input channel: i_valid / o_stall with i_coord_x, i_coord_y (signed,
// COORD_FRAC_BITS fraction bits). A request is taken on a clock edge with
// i_valid high and o_stall low.
// Output channel: o_valid / i_stall with o_spline_value (unsigned fraction,
// full scale just below 1.0). A result leaves on an edge with o_valid high
// and i_stall low.
// There are 4 fold, 5 polynomial and 2 output stages; no stage chains more than
// one 32x32 product. Throughput is one point per clock while nothing stalls.
// Every stage has its own valid bit, so empty stages keep filling while the
// output register is held by i_stall; o_stall rises only once the pipe is full.
// Stalled results stay in place and are never dropped or repeated.
// Reset (synchronous, active low) empties the pipe; no results are pending
// afterwards. There is no configuration and no state between points.
module three_direction_box_spline_eval_unit
    import tdbs_pkg::*;
#(
    parameter int COORD_WIDTH     = 16,
    parameter int COORD_FRAC_BITS = 12,
    parameter int RESULT_WIDTH    = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [COORD_WIDTH-1:0] i_coord_x,
    input  logic signed [COORD_WIDTH-1:0] i_coord_y,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [RESULT_WIDTH-1:0]       o_spline_value
);

    t_fold_data fold_data;
    logic       fold_valid;
    logic       fold_stall;
    t_poly_data poly_data;
    logic       poly_valid;
    logic       poly_stall;

    tdbs_fold #(
        .COORD_WIDTH     (COORD_WIDTH),
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_fold (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_coord_x (i_coord_x),
        .i_coord_y (i_coord_y),
        .o_valid   (fold_valid),
        .i_stall   (fold_stall),
        .o_data    (fold_data)
    );

    tdbs_poly u_poly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fold_valid),
        .o_stall (fold_stall),
        .i_data  (fold_data),
        .o_valid (poly_valid),
        .i_stall (poly_stall),
        .o_data  (poly_data)
    );

    tdbs_out #(
        .RESULT_WIDTH (RESULT_WIDTH)
    ) u_out (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (poly_valid),
        .o_stall        (poly_stall),
        .i_data         (poly_data),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_spline_value (o_spline_value)
    );

endmodule

// ===== tb/sv/tb_three_direction_box_spline_eval_unit.sv =====
// Self-checking testbench for the three-directional box spline evaluator
`timescale 1ns / 100ps

module tb_three_direction_box_spline_eval_unit;
    import tdbs_pkg::*;

    localparam int CW = 16;
    localparam int FB = 12;
    localparam int RW = 16;
    localparam int SHIFT_IN  = 28 - FB;
    localparam int SHIFT_OUT = 28 - RW;

    localparam longint C_ONE         = Q_ONE;
    localparam longint C_HALF        = Q_HALF;
    localparam longint C_QUARTER     = C_ONE >>> 2;
    localparam longint C_EIGHTH      = C_ONE >>> 3;
    localparam longint C_INV_SQRT3   = Q_INV_SQRT3;
    localparam longint C_FIVE_THIRDS = Q_FIVE_THIRDS;
    localparam longint C_FIVE_SIXTHS = Q_FIVE_SIXTHS;
    localparam longint C_THIRD       = Q_THIRD;
    localparam longint C_SIXTH       = Q_SIXTH;
    localparam longint COORD_CLAMP   = longint'(4) << FB;
    localparam longint VALUE_MAX     = (longint'(1) << RW) - 1;

    localparam int N_RANDOM    = 800;
    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 300;
    localparam int HOLD_AFTER  = 150;
    localparam int DRAIN       = 24;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic                 known;
        logic [RW-1:0]        value;
    } t_point;

    // known = 1: value is the result read straight off the formulas
    localparam int N_DIRECTED = 22;
    localparam t_point DIRECTED [N_DIRECTED] = '{
        '{16'sd0,       16'sd0,       1'b1, 16'd32768},  // origin, peak of the spline
        '{16'sh8000,    16'sh8000,    1'b1, 16'd0},      // most negative on both axes
        '{16'sh7fff,    16'sh7fff,    1'b1, 16'd0},
        '{16'sh8000,    16'sd0,       1'b1, 16'd0},
        '{16'sd0,       16'sh8000,    1'b1, 16'd0},
        '{16'sh7fff,    16'sh8000,    1'b1, 16'd0},
        '{16'sd16385,   16'sd0,       1'b1, 16'd0},      // just past the clamp
        '{-16'sd16384,  16'sd0,       1'b1, 16'd0},      // exactly 4.0
        '{16'sd8192,    16'sd0,       1'b1, 16'd0},      // outer corner at v = 2
        '{-16'sd8192,   16'sd0,       1'b1, 16'd0},
        '{16'sd4096,    16'sd0,       1'b0, 16'd0},      // v = 1 boundary
        '{16'sd4095,    16'sd0,       1'b0, 16'd0},
        '{16'sd0,       16'sd4096,    1'b0, 16'd0},
        '{16'sd0,       -16'sd7094,   1'b0, 16'd0},      // folded, just inside v = 2
        '{16'sd2048,    16'sd2048,    1'b0, 16'd0},
        '{-16'sd2048,   -16'sd3547,   1'b0, 16'd0},
        '{16'sd6000,    16'sd1000,    1'b0, 16'd0},
        '{16'sd1,       16'sd1,       1'b0, 16'd0},
        '{-16'sd1,      -16'sd1,      1'b0, 16'd0},
        '{16'sd8191,    16'sd0,       1'b0, 16'd0},      // tail rounds toward zero
        '{16'sd7000,    -16'sd3000,   1'b0, 16'd0},
        '{16'sd5000,    16'sd5000,    1'b0, 16'd0}
    };

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic signed [CW-1:0] i_coord_x = '0;
    logic signed [CW-1:0] i_coord_y = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic [RW-1:0]        o_spline_value;

    // sidecar of the request on the bus: typed result, if any
    logic                 row_known = 1'b0;
    logic [RW-1:0]        row_value = '0;

    logic [RW-1:0] pending_values [$];
    int            cycle_count = 0;
    int            n_errors = 0;
    int            n_checked = 0;
    int            n_accepted = 0;
    int            n_typed = 0;
    int            n_input_stalls = 0;
    int            zone_hits [4] = '{0, 0, 0, 0};
    bit            holding = 1'b0;

    three_direction_box_spline_eval_unit #(
        .COORD_WIDTH(CW),
        .COORD_FRAC_BITS(FB),
        .RESULT_WIDTH(RW)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_coord_x(i_coord_x),
        .i_coord_y(i_coord_y),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_spline_value(o_spline_value)
    );

    always #4 i_clk = ~i_clk;

    // Q.28 product, round to nearest, ties away from zero
    function automatic longint q28_mul(input longint a, input longint b);
        bit        neg;
        bit [63:0] ma;
        bit [63:0] mb;
        bit [63:0] p;
        neg = (a < 0) != (b < 0);
        ma  = (a < 0) ? -a : a;
        mb  = (b < 0) ? -b : b;
        p   = (ma * mb + (64'd1 << 27)) >> 28;
        return neg ? -longint'(p) : longint'(p);
    endfunction

    function automatic longint coord_q28(input logic signed [CW-1:0] c);
        longint m;
        m = c;
        if (m < 0) m = -m;
        if (m > COORD_CLAMP) m = COORD_CLAMP;
        return m << SHIFT_IN;
    endfunction

    function automatic logic [RW-1:0] box_spline_value(input logic signed [CW-1:0] cx,
                                                       input logic signed [CW-1:0] cy,
                                                       output t_region zone);
        longint ax, ay, u, v, r, g, gg, tg, t, d, s;
        longint unsigned m;
        ax = coord_q28(cx);
        ay = q28_mul(coord_q28(cy), C_INV_SQRT3);
        u  = ax - ay;
        v  = ax + ay;
        // fold into the fundamental sector
        if (u < 0) begin
            u = -u;
            v = v + u;
        end
        if (2 * u < v) u = v - u;
        r = 0;
        if (v > 2 * C_ONE) begin
            zone = REG_ZERO;
        end else begin
            g  = u - q28_mul(v, C_HALF);
            gg = q28_mul(g, g);
            tg = q28_mul(C_ONE - q28_mul(v, C_QUARTER), v) + q28_mul(gg, C_SIXTH) - C_ONE;
            tg = q28_mul(q28_mul(tg, g), g);
            if (v < C_ONE) begin
                zone = REG_INNER;
                t = q28_mul(C_FIVE_THIRDS - q28_mul(v, C_EIGHTH), v) - 3 * C_ONE;
                t = q28_mul(q28_mul(q28_mul(t, v), v), C_QUARTER);
                r = C_HALF + t + tg;
            end else if (u > C_ONE) begin
                zone = REG_OUTER;
                d = v - 2 * C_ONE;
                r = q28_mul(q28_mul(q28_mul(q28_mul(d, d), d), g - C_ONE), C_SIXTH);
            end else begin
                zone = REG_MIDDLE;
                s = C_ONE + q28_mul(C_THIRD - q28_mul(v, C_EIGHTH), v);
                s = q28_mul(q28_mul(s, v), C_QUARTER) - C_ONE;
                s = q28_mul(s, v);
                r = C_FIVE_SIXTHS + s + tg;
            end
        end
        if (r <= 0) return '0;
        m = r;
        m = (m + (64'd1 << (SHIFT_OUT - 1))) >> SHIFT_OUT;
        if (m > VALUE_MAX) m = VALUE_MAX;
        return m[RW-1:0];
    endfunction

    task automatic report_mismatch(input string what, input logic [RW-1:0] want,
                                   input logic [RW-1:0] got);
        n_errors++;
        if (n_errors <= 40)
            $display("cycle %0d: %s, expected %0d, got %0d", cycle_count, what, want, got);
    endtask

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_values.size());
            $display("FAIL three_direction_box_spline_eval_unit");
            $finish;
        end
    end

    always @(posedge i_clk) begin : scoreboard
        t_region       zone;
        logic [RW-1:0] want;
        if (i_rst_n && i_valid && o_stall) n_input_stalls++;
        if (i_rst_n && i_valid && !o_stall) begin
            want = box_spline_value(i_coord_x, i_coord_y, zone);
            if (row_known) begin
                want = row_value;
                n_typed++;
            end
            pending_values.push_back(want);
            zone_hits[zone]++;
            n_accepted++;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_values.size() == 0) begin
                report_mismatch("result with no request pending", '0, o_spline_value);
            end else begin
                want = pending_values.pop_front();
                n_checked++;
                if (o_spline_value !== want)
                    report_mismatch("spline_value", want, o_spline_value);
            end
        end
    end

    // result side: random stall per result, one long hold-off
    initial begin : result_sink
        int  n_taken;
        int  wait_cycles;
        bit  burst;
        bit  held;
        n_taken = 0;
        held    = 1'b0;
        burst   = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (n_taken % 64 == 0) burst = ($urandom_range(0, 2) == 0);
            if (n_taken == HOLD_AFTER && !held) begin
                held    = 1'b1;
                holding = 1'b1;
                i_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                holding = 1'b0;
            end else begin
                wait_cycles = burst ? 0 : $urandom_range(0, 15);
                if (wait_cycles != 0) begin
                    i_stall <= 1'b1;
                    repeat (wait_cycles) @(posedge i_clk);
                end
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            n_taken++;
        end
    end

    initial begin : point_source
        t_point plan [$];
        t_point item;
        int     gap;
        int     pick;
        int     tval;
        bit     burst;
        foreach (DIRECTED[k]) plan.push_back(DIRECTED[k]);
        for (int k = 0; k < N_RANDOM; k++) begin
            item.known = 1'b0;
            item.value = '0;
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                // mostly inside or near the support
                tval = int'($urandom_range(0, 18000)) - 9000;
                item.x = tval[CW-1:0];
                tval = int'($urandom_range(0, 16000)) - 8000;
                item.y = tval[CW-1:0];
            end else if (pick < 8) begin
                tval = int'($urandom_range(0, 600)) - 300;
                item.x = tval[CW-1:0];
                tval = int'($urandom_range(0, 600)) - 300;
                item.y = tval[CW-1:0];
            end else begin
                tval = $urandom;
                item.x = tval[CW-1:0];
                tval = $urandom;
                item.y = tval[CW-1:0];
            end
            plan.push_back(item);
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        burst = 1'b0;
        for (int k = 0; k < plan.size(); k++) begin
            if (k % 64 == 0) burst = ($urandom_range(0, 2) == 0);
            if (k == plan.size() / 2) begin
                // let the pipe drain completely before going on
                i_valid <= 1'b0;
                @(posedge i_clk);
                while (pending_values.size() != 0) @(posedge i_clk);
            end
            gap = (burst || holding) ? 0 : $urandom_range(0, 15);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_valid   <= 1'b1;
            i_coord_x <= plan[k].x;
            i_coord_y <= plan[k].y;
            row_known <= plan[k].known;
            row_value <= plan[k].value;
            @(posedge i_clk);
            while (o_stall) @(posedge i_clk);
        end
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_values.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);

        $display("Run covered %0d requests (%0d typed), %0d checked, %0d mismatches.",
                 n_accepted, n_typed, n_checked, n_errors);
        $display("Regions: inner %0d, middle %0d, outer %0d, outside %0d; input held %0d cycles.",
                 zone_hits[REG_INNER], zone_hits[REG_MIDDLE], zone_hits[REG_OUTER],
                 zone_hits[REG_ZERO], n_input_stalls);
        if (n_errors == 0)
            $display("PASS three_direction_box_spline_eval_unit");
        else
            $display("FAIL three_direction_box_spline_eval_unit");
        $finish;
    end

endmodule
